>>> src/pfe_pkg.sv
// Package for the protobuf field extractor: payload structs, parser phases,
// status and wire type codes. No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int TARGET_W    = 29;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef enum logic [2:0] {
    ST_VALUE    = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADWIRE  = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_last;
    status_t    status;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_TAG       = 3'd0,
    PH_LEN       = 3'd1,
    PH_SKIPVAR   = 3'd2,
    PH_SKIPBYTES = 3'd3,
    PH_EMIT      = 3'd4,
    PH_DONE      = 3'd5
  } phase_t;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  localparam logic [6:0] SHIFT_STEP = 7'd7;
  localparam logic [6:0] SHIFT_SAT  = 7'd70;
  localparam logic [6:0] ACC_BITS   = 7'd64;

endpackage

>>> src/protobuf_field_extractor_unit.sv
// Results are written into the two-entry queue when the byte is accepted, then
// loaded into the output register (queue write, then output register load).
// Throughput: one byte per cycle while in_ready is high, set by the parser state update.
// in_ready drops only while the two-entry result queue is full.
// Reset (synchronous, rst_n low): parser to tag phase, target field number to 1,
// queue and output register empty.
`timescale 1ns / 1ps

module protobuf_field_extractor_unit import pfe_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_wdata
);

  logic      fire;
  logic      push;
  out_item_t push_data;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  out_item_t q_head;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  pfe_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/pfe_front.sv
// Front end: accepts message bytes, decodes tags and lengths, skips fields
// and produces at most one result transaction per byte. Uses pfe_pkg.
`timescale 1ns / 1ps

module pfe_front import pfe_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_wdata,
  input  logic                fire,
  input  in_item_t            in_data,
  output logic                push,
  output out_item_t           push_data
);

  localparam logic [LENGTH_BITS-1:0] LEN_I64 = LENGTH_BITS'(8);
  localparam logic [LENGTH_BITS-1:0] LEN_I32 = LENGTH_BITS'(4);

  phase_t                 phase_r, phase_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [6:0]             shift_r, shift_nxt;
  logic                   match_r, match_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [TARGET_W-1:0]    target_r;

  logic [63:0]            acc_upd;
  logic [7:0]             shift_sum;
  logic [6:0]             shift_inc;
  logic                   vdone;
  logic                   len_sat;
  logic [LENGTH_BITS-1:0] len_val;
  logic [LENGTH_BITS-1:0] left_dec;
  logic                   have;
  status_t                st;
  logic [7:0]             vb;
  logic                   vl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_W'(1);
    end else if (cfg_we) begin
      target_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      shift_r <= '0;
      match_r <= 1'b0;
      left_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      match_r <= match_nxt;
      left_r  <= left_nxt;
    end
  end

  always_comb begin
    // bits past 64 are dropped
    acc_upd   = (shift_r < ACC_BITS) ? (acc_r | ({56'd0, 1'b0, in_data.data_byte[6:0]} << shift_r))
                                     : acc_r;
    vdone     = !in_data.data_byte[7];
    shift_sum = {1'b0, shift_r} + {1'b0, SHIFT_STEP};
    shift_inc = (shift_sum > {1'b0, SHIFT_SAT}) ? SHIFT_SAT : shift_sum[6:0];
    len_sat   = |(acc_upd >> LENGTH_BITS);
    len_val   = len_sat ? '1 : acc_upd[LENGTH_BITS-1:0];
    left_dec  = left_r - LENGTH_BITS'(1);

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    match_nxt = match_r;
    left_nxt  = left_r;
    have      = 1'b0;
    st        = ST_VALUE;
    vb        = '0;
    vl        = 1'b0;

    if (fire) begin
      unique case (phase_r)
        PH_TAG: begin
          if (vdone) begin
            match_nxt = (acc_upd[34:3] == {3'd0, target_r});
            acc_nxt   = '0;
            shift_nxt = '0;
            unique case (acc_upd[2:0])
              WT_VARINT: phase_nxt = PH_SKIPVAR;
              WT_I64: begin
                left_nxt  = LEN_I64;
                phase_nxt = PH_SKIPBYTES;
              end
              WT_I32: begin
                left_nxt  = LEN_I32;
                phase_nxt = PH_SKIPBYTES;
              end
              WT_LEN: phase_nxt = PH_LEN;
              default: begin
                have      = 1'b1;
                st        = ST_BADWIRE;
                vl        = 1'b1;
                phase_nxt = PH_DONE;
              end
            endcase
          end else begin
            acc_nxt   = acc_upd;
            shift_nxt = shift_inc;
          end
        end
        PH_LEN: begin
          if (vdone) begin
            acc_nxt   = '0;
            shift_nxt = '0;
            left_nxt  = len_val;
            if (match_r) begin
              if (len_val == '0) begin
                have      = 1'b1;
                st        = ST_EMPTY;
                vl        = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_EMIT;
              end
            end else begin
              phase_nxt = (len_val == '0) ? PH_TAG : PH_SKIPBYTES;
            end
          end else begin
            acc_nxt   = acc_upd;
            shift_nxt = shift_inc;
          end
        end
        PH_SKIPVAR: begin
          if (vdone) begin
            acc_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = PH_TAG;
          end else begin
            acc_nxt   = acc_upd;
            shift_nxt = shift_inc;
          end
        end
        PH_SKIPBYTES: begin
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_TAG;
        end
        PH_EMIT: begin
          left_nxt = left_dec;
          have     = 1'b1;
          vb       = in_data.data_byte;
          if (left_dec == '0) begin
            vl        = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      if (in_data.last_byte) begin
        if (!have) begin
          if (phase_nxt == PH_TAG && shift_nxt == '0) begin
            have = 1'b1;
            st   = ST_NOTFOUND;
            vl   = 1'b1;
          end else if (phase_nxt != PH_DONE) begin
            have = 1'b1;
            st   = ST_TRUNC;
            vl   = 1'b1;
          end
        end else if (st == ST_VALUE && !vl) begin
          // payload cut short by end of buffer
          st = ST_TRUNC;
          vb = '0;
          vl = 1'b1;
        end
        phase_nxt = PH_TAG;
        acc_nxt   = '0;
        shift_nxt = '0;
        left_nxt  = '0;
        match_nxt = 1'b0;
      end
    end

    push                 = have;
    push_data.value_byte = vb;
    push_data.value_last = vl;
    push_data.status     = st;
  end

endmodule

>>> src/pfe_queue.sv
// Short result queue between parser and output stage.
// Uses pfe_pkg for the result struct and depth.
`timescale 1ns / 1ps

module pfe_queue import pfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output out_item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

>>> src/pfe_back.sv
// Back end: output register that drains the result queue toward the consumer.
// Uses pfe_pkg for the result struct.
`timescale 1ns / 1ps

module pfe_back import pfe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  out_item_t q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r;
  out_item_t data_r;

  // load when the register is empty or its transaction leaves this cycle
  assign q_pop = q_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_head;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> src/pfe_checker.sv
// Port-level checks for protobuf_field_extractor_unit, attached by bind.
// Uses pfe_pkg for the status codes.
`timescale 1ns / 1ps

module pfe_checker import pfe_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_VALUE |-> out_data.value_last)
    else $error("status result without value_last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_VALUE |-> out_data.value_byte == 8'd0)
    else $error("status result with nonzero value_byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind protobuf_field_extractor_unit pfe_checker u_pfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/protobuf_field_extractor_unit_tb.sv
// Self-checking testbench for protobuf_field_extractor_unit: directed and random wire-format
// messages, a byte-level parse predictor and a scoreboard on the result channel.
// Depends on pfe_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module protobuf_field_extractor_unit_tb;
  import pfe_pkg::*;

  localparam int LEN_BITS = 32;
  localparam logic [TARGET_W-1:0] TARGET_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [TARGET_W-1:0] cfg_wdata = '0;

  protobuf_field_extractor_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  in_item_t   pending_bytes[$];
  out_item_t  expected_results[$];
  logic [7:0] msg_buf[$];
  int         send_idle = 22;
  int         recv_idle = 52;
  int         mismatches = 0;
  int         bytes_queued = 0;

  // Parser state as predicted
  logic [TARGET_W-1:0] tgt_field = TARGET_W'(1);
  phase_t              cur_phase = PH_TAG;
  logic [63:0]         vacc = '0;
  logic [6:0]          vshift = '0;
  logic [2:0]          wtype = '0;
  logic                is_target = 1'b0;
  logic [LEN_BITS-1:0] remain = '0;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // Returns 1 when this byte closes the varint; high bits past 64 fall off.
  function automatic bit take_varint(input logic [7:0] b);
    if (vshift < ACC_BITS) vacc = vacc | (64'(b[6:0]) << vshift);
    if (!b[7]) return 1'b1;
    vshift = vshift + SHIFT_STEP;
    if (vshift > SHIFT_SAT) vshift = SHIFT_SAT;
    return 1'b0;
  endfunction

  task automatic parse_byte(input in_item_t it);
    logic [7:0]  b;
    bit          have;
    status_t     st;
    logic [7:0]  vb;
    logic        vl;
    logic [31:0] fnum;
    logic [63:0] n;
    out_item_t   res;
    b = it.data_byte;
    have = 1'b0;
    st = ST_VALUE;
    vb = '0;
    vl = 1'b0;
    case (cur_phase)
      PH_TAG: begin
        if (take_varint(b)) begin
          fnum = vacc[34:3];
          wtype = vacc[2:0];
          is_target = (fnum == 32'(tgt_field));
          vacc = '0;
          vshift = '0;
          case (wtype)
            WT_VARINT: cur_phase = PH_SKIPVAR;
            WT_I64: begin
              remain = LEN_BITS'(8);
              cur_phase = PH_SKIPBYTES;
            end
            WT_I32: begin
              remain = LEN_BITS'(4);
              cur_phase = PH_SKIPBYTES;
            end
            WT_LEN: cur_phase = PH_LEN;
            default: begin
              have = 1'b1;
              st = ST_BADWIRE;
              vl = 1'b1;
              cur_phase = PH_DONE;
            end
          endcase
        end
      end
      PH_LEN: begin
        if (take_varint(b)) begin
          n = vacc;
          vacc = '0;
          vshift = '0;
          // saturate lengths that do not fit the counter
          if ((n >> LEN_BITS) != 0) remain = '1;
          else remain = n[LEN_BITS-1:0];
          if (is_target) begin
            if (n == 0) begin
              have = 1'b1;
              st = ST_EMPTY;
              vl = 1'b1;
              cur_phase = PH_DONE;
            end else begin
              cur_phase = PH_EMIT;
            end
          end else begin
            cur_phase = (n == 0) ? PH_TAG : PH_SKIPBYTES;
          end
        end
      end
      PH_SKIPVAR: begin
        if (take_varint(b)) begin
          vacc = '0;
          vshift = '0;
          cur_phase = PH_TAG;
        end
      end
      PH_SKIPBYTES: begin
        remain = remain - 1'b1;
        if (remain == 0) cur_phase = PH_TAG;
      end
      PH_EMIT: begin
        remain = remain - 1'b1;
        have = 1'b1;
        st = ST_VALUE;
        vb = b;
        if (remain == 0) begin
          vl = 1'b1;
          cur_phase = PH_DONE;
        end
      end
      default: ;
    endcase

    if (it.last_byte) begin
      if (!have) begin
        if (cur_phase == PH_TAG && vshift == 0) begin
          have = 1'b1;
          st = ST_NOTFOUND;
          vl = 1'b1;
        end else if (cur_phase != PH_DONE) begin
          have = 1'b1;
          st = ST_TRUNC;
          vl = 1'b1;
        end
      end else if (st == ST_VALUE && !vl) begin
        // end of buffer inside the payload replaces the byte
        st = ST_TRUNC;
        vb = '0;
        vl = 1'b1;
      end
      cur_phase = PH_TAG;
      vacc = '0;
      vshift = '0;
      remain = '0;
      is_target = 1'b0;
    end

    if (have) begin
      res.value_byte = vb;
      res.value_last = vl;
      res.status = st;
      expected_results = {expected_results, res};
    end
  endtask

  // Driver: hold each transaction until accepted, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) parse_byte(in_data);
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : mon
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte %02h last %0b status %0d",
                                  out_data.value_byte, out_data.value_last, out_data.status));
        end else begin
          want = expected_results.pop_front();
          if (out_data.value_byte !== want.value_byte)
            flag_mismatch($sformatf("value_byte %02h, want %02h",
                                    out_data.value_byte, want.value_byte));
          if (out_data.value_last !== want.value_last)
            flag_mismatch($sformatf("value_last %0b, want %0b",
                                    out_data.value_last, want.value_last));
          if (out_data.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic queue_msg(input int cut);
    in_item_t it;
    for (int i = 0; i < cut; i++) begin
      it.data_byte = msg_buf[i];
      it.last_byte = (i == cut - 1);
      pending_bytes = {pending_bytes, it};
      bytes_queued++;
    end
    msg_buf.delete();
  endtask

  // Append a varint; pad adds overlong continuation bytes, with random payload if junk.
  task automatic add_varint(input logic [63:0] v, input int pad, input bit junk);
    logic [63:0] r;
    logic [7:0]  b;
    int          p;
    r = v;
    p = pad;
    while (1) begin
      b = {1'b0, r[6:0]};
      r = r >> 7;
      if (r == 0 && p == 0) begin
        msg_buf = {msg_buf, b};
        break;
      end
      if (r == 0) begin
        p--;
        if (junk) r = 64'($urandom_range(0, 127)) & 64'h7F;
        if (p == 0 && r == 0 && junk) r = 1;
      end
      msg_buf = {msg_buf, b | 8'h80};
    end
  endtask

  task automatic add_field(output bit stop);
    int          k;
    logic [60:0] fnum;
    logic [31:0] hi;
    logic [2:0]  wt;
    logic [63:0] v;
    int          len;
    stop = 1'b0;
    hi = $urandom;
    k = $urandom_range(99);
    if (k < 45) fnum = 61'(tgt_field);
    else if (k < 53) fnum = {hi[28:0], 32'(tgt_field)};  // upper tag bits dropped
    else if (k < 61) fnum = 61'(32'(tgt_field) ^ (32'd1 << $urandom_range(0, 31)));
    else if (k < 80) fnum = 61'($urandom_range(0, 15));
    else fnum = 61'($urandom);

    k = $urandom_range(99);
    if (k < 20) wt = WT_VARINT;
    else if (k < 30) wt = WT_I64;
    else if (k < 40) wt = WT_I32;
    else if (k < 95) wt = WT_LEN;
    else begin
      case ($urandom_range(3))
        0: wt = 3'd3;
        1: wt = 3'd4;
        2: wt = 3'd6;
        default: wt = 3'd7;
      endcase
    end

    add_varint({fnum, wt}, ($urandom_range(19) == 0) ? $urandom_range(1, 10) : 0, 1'b0);

    case (wt)
      WT_VARINT: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(7) == 0) add_varint(v, $urandom_range(1, 12), 1'b1);
        else add_varint(v, 0, 1'b0);
      end
      WT_I64: repeat (8) msg_buf = {msg_buf, 8'($urandom)};
      WT_I32: repeat (4) msg_buf = {msg_buf, 8'($urandom)};
      WT_LEN: begin
        if ($urandom_range(19) == 0) begin
          // large length: no further field follows it
          v = {$urandom, $urandom};
          if ($urandom_range(1) == 0) v[63:32] = v[63:32] | 32'h1;
          else v = v >> 40;
          add_varint(v, 0, 1'b0);
          repeat ($urandom_range(0, 4)) msg_buf = {msg_buf, 8'($urandom)};
          stop = 1'b1;
        end else begin
          len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
          add_varint(64'(len), ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
          repeat (len) msg_buf = {msg_buf, 8'($urandom)};
        end
      end
      default: begin
        repeat ($urandom_range(0, 3)) msg_buf = {msg_buf, 8'($urandom)};
        stop = 1'b1;
      end
    endcase
  endtask

  task automatic queue_random_msg();
    int nf;
    int cut;
    bit stop;
    msg_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) msg_buf = {msg_buf, 8'($urandom)};
    end else begin
      nf = $urandom_range(1, 4);
      stop = 1'b0;
      for (int i = 0; i < nf && !stop; i++) add_field(stop);
    end
    cut = msg_buf.size();
    // cut the buffer short now and then
    if ($urandom_range(4) == 0) cut = $urandom_range(1, msg_buf.size());
    queue_msg(cut);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_target(input logic [TARGET_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_field = v;
    @(negedge clk);
  endtask

  initial begin
    int goal;
    logic [TARGET_W-1:0] t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed messages against the reset target
    msg_buf = '{8'h0A, 8'h02, 8'hAB, 8'hCD};          // two payload bytes
    queue_msg(msg_buf.size());
    msg_buf = '{8'h08, 8'h96, 8'h01, 8'h0A, 8'h00};   // skip varint, empty target
    queue_msg(msg_buf.size());
    msg_buf = '{8'h0B, 8'h55};                        // bad wire type, trailing ignored
    queue_msg(msg_buf.size());
    msg_buf = '{8'h15, 8'h00, 8'hFF, 8'h00, 8'hFF};   // fixed32 skip, not found
    queue_msg(msg_buf.size());
    msg_buf = '{8'h0A, 8'h05, 8'h11};                 // payload cut short
    queue_msg(msg_buf.size());
    msg_buf = '{8'hFF};                               // tag cut short
    queue_msg(msg_buf.size());
    msg_buf = '{8'h12, 8'h00};                        // other field, zero length
    queue_msg(msg_buf.size());
    msg_buf = '{8'h0A, 8'h01, 8'h00};                 // single zero payload byte
    queue_msg(msg_buf.size());
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          send_idle = 22;
          recv_idle = 52;
        end
        1: begin
          send_idle = 52;
          recv_idle = 22;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (p)
        0: t = '0;
        1: t = TARGET_MAX;
        2: t = TARGET_W'($urandom_range(1, 15));
        3: t = TARGET_W'(1);
        4: t = TARGET_W'($urandom);
        5: t = '0;
        6: t = TARGET_MAX;
        7: t = TARGET_W'($urandom_range(2, 31));
        default: t = TARGET_W'($urandom);
      endcase
      write_target(t);
      goal = bytes_queued + 125;
      while (bytes_queued < goal) queue_random_msg();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("protobuf_field_extractor_unit_tb: PASS");
    end else begin
      $display("protobuf_field_extractor_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("protobuf_field_extractor_unit_tb: FAIL");
    $finish;
  end

endmodule
